// ===== hw/rtl/pssp_pkg.sv =====
// Shared types, constants and helpers for the proof-set stream parser.
`default_nettype none
package pssp_pkg;

    localparam int unsigned HDR_BYTES   = 12;
    localparam int unsigned ROOT_BYTES  = 32;
    localparam int unsigned OFF_W       = $clog2(ROOT_BYTES);
    localparam int unsigned POS_W       = 17;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam int unsigned MAX_ROOTS   = 1024;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned LEN_W       = 22;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_CAPACITY    = 2'd1;

    localparam logic [15:0] RST_EXPECTED_VERSION = 16'd1;
    localparam logic [15:0] RST_ROOT_CAPACITY    = 16'd1024;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MAGIC     = 3'd1,
        ST_VERSION   = 3'd2,
        ST_COUNT     = 3'd3,
        ST_LENGTH    = 3'd4,
        ST_ZERO_ROOT = 3'd5,
        ST_ORDER     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        ORD_EQ      = 2'd0,
        ORD_LESS    = 2'd1,
        ORD_GREATER = 2'd2
    } t_order;

    typedef enum logic [2:0] {
        K_MAGIC    = 3'd0,
        K_VER_LO   = 3'd1,
        K_VER_HI   = 3'd2,
        K_CNT_LO   = 3'd3,
        K_CNT_HI   = 3'd4,
        K_ROOT     = 3'd5,
        K_ROOT_SAT = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [POS_W-1:0] pos;
        t_kind            kind;
        logic [15:0]      root_index;
        logic [OFF_W-1:0] offset;
    } t_item;

    typedef struct packed {
        logic [15:0] expected_version;
        logic [15:0] root_capacity;
    } t_cfg;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'h5A;
            3'd1: b = 8'h43;
            3'd2: b = 8'h50;
            3'd3: b = 8'h53;
            3'd4: b = 8'h45;
            3'd5: b = 8'h54;
            3'd6: b = 8'h0D;
            3'd7: b = 8'h0A;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pssp_front.sv =====
// Front end: frame byte counter and classification of each accepted item.
`default_nettype none
module pssp_front
    import pssp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  [7:0] i_in_byte,
    input  wire logic  i_last,
    input  wire logic  i_full,
    output logic       o_push,
    output t_item      o_item
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] rel;
    logic             sat;
    logic             is_root;

    assign o_push  = i_valid && !i_full;
    assign sat     = (r_pos == POS_MAX);
    assign is_root = (r_pos >= POS_W'(HDR_BYTES));
    assign rel     = r_pos - POS_W'(HDR_BYTES);

    always_comb begin
        o_item.data       = i_in_byte;
        o_item.last       = i_last;
        o_item.pos        = r_pos;
        o_item.offset     = rel[OFF_W-1:0];
        o_item.root_index = is_root ? 16'(rel >> OFF_W) : 16'd0;
        priority if (r_pos < POS_W'(8))       o_item.kind = K_MAGIC;
        else if (r_pos == POS_W'(8))          o_item.kind = K_VER_LO;
        else if (r_pos == POS_W'(9))          o_item.kind = K_VER_HI;
        else if (r_pos == POS_W'(10))         o_item.kind = K_CNT_LO;
        else if (r_pos == POS_W'(11))         o_item.kind = K_CNT_HI;
        else if (sat)                         o_item.kind = K_ROOT_SAT;
        else                                  o_item.kind = K_ROOT;
    end

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_last)    n_pos = '0;
            else if (!sat) n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pssp_queue.sv =====
// Short item queue between the front end and the checking back end.
`default_nettype none
module pssp_queue
    import pssp_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pssp_back.sv =====
// Back end: header and root checks, status on the last item, output register.
`default_nettype none
module pssp_back
    import pssp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_empty,
    input  wire t_item i_item,
    output logic       o_pop,
    input  wire logic  i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_byte_is_root,
    output logic [15:0] o_root_index,
    output logic       o_done_res,
    output logic [2:0] o_status,
    output logic [15:0] o_root_count
);

    // frame state
    logic        r_magic_bad, n_magic_bad;
    logic [15:0] r_hver, n_hver;
    logic [15:0] r_hcnt, n_hcnt;
    t_order      r_order, n_order;
    logic        r_nonzero, n_nonzero;
    t_status     r_first_err, n_first_err;
    logic [7:0]  r_prev [ROOT_BYTES];

    // output register
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_oroot;
    logic [15:0] r_oindex;
    logic        r_odone;
    t_status     r_ostatus;
    logic [15:0] r_ocount;

    t_order      base_order;
    logic        base_nz;
    logic [7:0]  prev_b;
    t_status     status;
    logic [15:0] count_out;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] exp_len;

    assign o_pop = !i_empty && (!r_ovalid || !i_stall);

    always_comb begin
        n_magic_bad = r_magic_bad;
        n_hver      = r_hver;
        n_hcnt      = r_hcnt;
        n_order     = r_order;
        n_nonzero   = r_nonzero;
        n_first_err = r_first_err;
        prev_b      = r_prev[i_item.offset];
        base_order  = (i_item.offset == '0) ? ORD_EQ : r_order;
        base_nz     = (i_item.offset == '0) ? 1'b0 : r_nonzero;
        unique case (i_item.kind)
            K_MAGIC: begin
                if (i_item.data != magic_byte(i_item.pos[2:0])) n_magic_bad = 1'b1;
            end
            K_VER_LO: n_hver = {r_hver[15:8], i_item.data};
            K_VER_HI: n_hver = {i_item.data, r_hver[7:0]};
            K_CNT_LO: n_hcnt = {r_hcnt[15:8], i_item.data};
            K_CNT_HI: n_hcnt = {i_item.data, r_hcnt[7:0]};
            K_ROOT: begin
                n_order = base_order;
                if (base_order == ORD_EQ) begin
                    if (prev_b < i_item.data)      n_order = ORD_LESS;
                    else if (prev_b > i_item.data) n_order = ORD_GREATER;
                end
                n_nonzero = base_nz || (i_item.data != 8'd0);
                // verdict for a root is taken on its last byte; first failing root wins
                if (i_item.offset == OFF_W'(ROOT_BYTES - 1) && r_first_err == ST_OK) begin
                    if (!n_nonzero) begin
                        n_first_err = ST_ZERO_ROOT;
                    end else if (i_item.root_index != 16'd0 && n_order != ORD_LESS) begin
                        n_first_err = ST_ORDER;
                    end
                end
            end
            K_ROOT_SAT: ;
            default: ;
        endcase
    end

    always_comb begin
        len       = LEN_W'(i_item.pos) + LEN_W'(1);
        exp_len   = (LEN_W'(n_hcnt) << OFF_W) + LEN_W'(HDR_BYTES);
        status    = ST_OK;
        count_out = 16'd0;
        if (i_item.last) begin
            priority if (len < LEN_W'(HDR_BYTES) || n_magic_bad) begin
                status = ST_MAGIC;
            end else if (n_hver != i_cfg.expected_version) begin
                status = ST_VERSION;
            end else if (n_hcnt == 16'd0 || n_hcnt > 16'(MAX_ROOTS)
                         || n_hcnt > i_cfg.root_capacity) begin
                status = ST_COUNT;
            end else if (len != exp_len) begin
                status = ST_LENGTH;
            end else if (n_first_err != ST_OK) begin
                status = n_first_err;
            end else begin
                count_out = n_hcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_bad <= 1'b0;
            r_hver      <= '0;
            r_hcnt      <= '0;
            r_order     <= ORD_EQ;
            r_nonzero   <= 1'b0;
            r_first_err <= ST_OK;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_magic_bad <= 1'b0;
                r_hver      <= '0;
                r_hcnt      <= '0;
                r_order     <= ORD_EQ;
                r_nonzero   <= 1'b0;
                r_first_err <= ST_OK;
            end else begin
                r_magic_bad <= n_magic_bad;
                r_hver      <= n_hver;
                r_hcnt      <= n_hcnt;
                r_order     <= n_order;
                r_nonzero   <= n_nonzero;
                r_first_err <= n_first_err;
            end
        end
    end

    // previous root bytes survive frame boundaries; only written roots are compared
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.kind == K_ROOT) begin
            r_prev[i_item.offset] <= i_item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_pop) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_obyte   <= i_item.data;
            r_oroot   <= (i_item.kind == K_ROOT || i_item.kind == K_ROOT_SAT);
            r_oindex  <= i_item.root_index;
            r_odone   <= i_item.last;
            r_ostatus <= status;
            r_ocount  <= count_out;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_out_byte     = r_obyte;
    assign o_byte_is_root = r_oroot;
    assign o_root_index   = r_oindex;
    assign o_done_res     = r_odone;
    assign o_status       = r_ostatus;
    assign o_root_count   = r_ocount;

endmodule
`default_nettype wire

// ===== hw/rtl/proof_set_stream_parser.sv =====
// Top level of the proof-set stream parser: configuration registers and datapath.
`default_nettype none
// Checks a proof-set frame one byte per item: 8-byte magic, LE16 version, LE16 root
// count n, then n roots of 32 bytes. Every byte comes back out, tagged as root data
// with its root index; the byte marked last carries the frame status and, when ok,
// the root count. Sustained rate is one item per clock while the output is not
// stalled. An accepted item is written into its queue entry and then loaded into
// the output register, from which the receiver takes it. The back end's critical
// path is a single read of the 32-byte previous-root store plus a byte compare.
// The two-entry queue lets input keep flowing for two items while the output is
// stalled. Configuration (index 0 expected version, index 1 root capacity) is
// always ready and must only be written between frames once all results have
// been taken. No memory initialization is needed after reset.
module proof_set_stream_parser
    import pssp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire logic  [7:0] i_in_byte,
    input  wire logic  i_last,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_is_root,
    output logic [15:0] o_root_index,
    output logic       o_done_res,
    output logic [2:0] o_status,
    output logic [15:0] o_root_count,
    input  wire logic  i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire logic  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic  [15:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  full;
    logic  empty;
    logic  push;
    logic  pop;
    t_item front_item;
    t_item queue_item;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version <= RST_EXPECTED_VERSION;
            r_cfg.root_capacity    <= RST_ROOT_CAPACITY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_EXPECTED_VERSION: r_cfg.expected_version <= i_cfg_data;
                CFG_ROOT_CAPACITY:    r_cfg.root_capacity    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pssp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_last    (i_last),
        .i_full    (full),
        .o_push    (push),
        .o_item    (front_item)
    );

    pssp_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    pssp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_empty        (empty),
        .i_item         (queue_item),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_byte_is_root (o_byte_is_root),
        .o_root_index   (o_root_index),
        .o_done_res     (o_done_res),
        .o_status       (o_status),
        .o_root_count   (o_root_count)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/pssp_chk.sv =====
// Port-level checker for the proof-set stream parser and its bind.
`default_nettype none
module pssp_chk
    import pssp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_byte_is_root,
    input wire logic [15:0] o_root_index,
    input wire logic        o_done_res,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_root_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_done_res)
                               && $stable(o_status) && $stable(o_root_count))
        else $error("output item changed while stalled");

    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_status == ST_OK && o_root_count == 16'd0)
        else $error("status or count reported on a non-final item");

    a_count_only_when_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res && o_status != ST_OK |-> o_root_count == 16'd0)
        else $error("root count reported with an error status");

    a_ok_has_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res && o_status == ST_OK |-> o_root_count != 16'd0
                                                     && o_byte_is_root)
        else $error("ok frame without roots");

    a_header_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_is_root |-> o_root_index == 16'd0)
        else $error("header item carries a root index");

endmodule

bind proof_set_stream_parser pssp_chk u_pssp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_byte     (o_out_byte),
    .o_byte_is_root (o_byte_is_root),
    .o_root_index   (o_root_index),
    .o_done_res     (o_done_res),
    .o_status       (o_status),
    .o_root_count   (o_root_count)
);
`default_nettype wire

// ===== verif/pssp_frame_checker.sv =====
// Frame checker for the proof-set stream parser: tracks frames, predicts each echo, compares.
module pssp_frame_checker
    import pssp_pkg::*;
#(
    parameter logic [63:0] MAGIC = 64'h5A43_5053_4554_0D0A
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic [7:0]           i_res_byte,
    input  logic                 i_res_is_root,
    input  logic [15:0]          i_res_root_index,
    input  logic                 i_res_done,
    input  logic [2:0]           i_res_status,
    input  logic [15:0]          i_res_count,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output int                   o_mismatches,
    output int                   o_backlog
);

    typedef struct packed {
        logic [7:0]  echo;
        logic        in_roots;
        logic [15:0] root_idx;
        logic        done;
        t_status     status;
        logic [15:0] count;
    } t_expected_echo;

    t_expected_echo expected_echoes[$];
    int mismatches = 0;

    // configuration copy
    logic [15:0] want_ver;
    logic [15:0] cap;

    // frame state
    logic [POS_W-1:0] f_pos;
    logic [7:0]       f_prev [ROOT_BYTES];
    logic [15:0]      f_ver;
    logic [15:0]      f_cnt;
    logic [15:0]      f_root;
    t_order           f_order;
    logic             f_nonzero;
    logic             f_magic_bad;
    t_status          f_first_err;

    task automatic clear_frame();
        f_pos       = '0;
        f_ver       = '0;
        f_cnt       = '0;
        f_root      = '0;
        f_order     = ORD_EQ;
        f_nonzero   = 1'b0;
        f_magic_bad = 1'b0;
        f_first_err = ST_OK;
    endtask

    task automatic track_frame_byte(input logic [7:0] b, input logic fin);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] rel;
        logic [OFF_W-1:0] off;
        logic [POS_W:0]   len;
        t_expected_echo   e;
        pos = f_pos;
        e = '0;
        e.echo = b;
        e.in_roots = (pos >= HDR_BYTES);
        e.root_idx = e.in_roots ? 16'((pos - HDR_BYTES) / ROOT_BYTES) : 16'd0;
        e.done = fin;
        e.status = ST_OK;

        if (pos < 8) begin
            if (b != MAGIC[63 - 8*pos -: 8]) f_magic_bad = 1'b1;
        end else if (pos == 8) begin
            f_ver[7:0] = b;
        end else if (pos == 9) begin
            f_ver[15:8] = b;
        end else if (pos == 10) begin
            f_cnt[7:0] = b;
        end else if (pos == 11) begin
            f_cnt[15:8] = b;
        end else if (pos != POS_MAX) begin
            // root checks freeze once the position counter saturates
            rel = pos - HDR_BYTES;
            off = rel[OFF_W-1:0];
            f_root = 16'(rel / ROOT_BYTES);
            if (off == 0) begin
                f_order = ORD_EQ;
                f_nonzero = 1'b0;
            end
            if (f_order == ORD_EQ) begin
                if (f_prev[off] < b) f_order = ORD_LESS;
                else if (f_prev[off] > b) f_order = ORD_GREATER;
            end
            f_prev[off] = b;
            if (b != 8'd0) f_nonzero = 1'b1;
            if (off == OFF_W'(ROOT_BYTES - 1) && f_first_err == ST_OK) begin
                if (!f_nonzero) f_first_err = ST_ZERO_ROOT;
                else if (f_root > 0 && f_order != ORD_LESS) f_first_err = ST_ORDER;
            end
        end

        if (fin) begin
            len = {1'b0, pos} + 1'b1;
            if (len < HDR_BYTES || f_magic_bad) e.status = ST_MAGIC;
            else if (f_ver != want_ver) e.status = ST_VERSION;
            else if (f_cnt == 0 || f_cnt > MAX_ROOTS || f_cnt > cap) e.status = ST_COUNT;
            else if (len != HDR_BYTES + ROOT_BYTES * f_cnt) e.status = ST_LENGTH;
            else if (f_first_err != ST_OK) e.status = f_first_err;
            else e.count = f_cnt;
            clear_frame();
        end else if (pos != POS_MAX) begin
            f_pos = pos + 1'b1;
        end
        expected_echoes.push_back(e);
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_expected_echo head;
        if (!i_rst_n) begin
            want_ver = RST_EXPECTED_VERSION;
            cap = RST_ROOT_CAPACITY;
            foreach (f_prev[j]) f_prev[j] = 8'd0;
            clear_frame();
            expected_echoes.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_echoes.size() == 0) begin
                    $error("result with no item pending: out_byte %0d", i_res_byte);
                    mismatches++;
                end else begin
                    head = expected_echoes.pop_front();
                    compare_field("out_byte", 16'(head.echo), 16'(i_res_byte));
                    compare_field("byte_is_root", 16'(head.in_roots), 16'(i_res_is_root));
                    compare_field("root_index", head.root_idx, i_res_root_index);
                    compare_field("done_res", 16'(head.done), 16'(i_res_done));
                    compare_field("status", 16'(head.status), 16'(i_res_status));
                    compare_field("root_count", head.count, i_res_count);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EXPECTED_VERSION: want_ver = i_cfg_data;
                    CFG_ROOT_CAPACITY:    cap = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) track_frame_byte(i_in_byte, i_in_last);
        end
        o_backlog = expected_echoes.size();
        o_mismatches = mismatches;
    end

endmodule

// ===== verif/tb_proof_set_stream_parser.sv =====
// Testbench top for the proof-set stream parser: frame stimulus, flow control and verdict.
module tb_proof_set_stream_parser;
    import pssp_pkg::*;

    localparam logic [63:0] FRAME_MAGIC = 64'h5A43_5053_4554_0D0A; // "ZCPSET" CR LF
    localparam int HDR_LEN = HDR_BYTES;
    localparam int ROOT_LEN = ROOT_BYTES;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam longint TIMEOUT = 64'd40_000_000;

    typedef enum {SPOIL_ZERO, SPOIL_EQUAL, SPOIL_LOWER} t_spoil;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 src_valid = 1'b0;
    logic [7:0]           src_byte = 8'd0;
    logic                 src_last = 1'b0;
    logic                 dst_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = 16'd0;

    logic        dut_stall;
    logic        res_valid;
    logic [7:0]  res_byte;
    logic        res_is_root;
    logic [15:0] res_root_index;
    logic        res_done;
    logic [2:0]  res_status;
    logic [15:0] res_count;
    logic        cfg_ready;

    int mismatches;
    int backlog;

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int holds_asked = 0;
    int holds_done = 0;
    int items_sent = 0;

    logic [15:0] cur_ver = RST_EXPECTED_VERSION;
    logic [15:0] cur_cap = RST_ROOT_CAPACITY;
    logic [7:0]  frame_q[$];

    always #10 clk = ~clk;

    proof_set_stream_parser dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (src_valid),
        .o_stall       (dut_stall),
        .i_in_byte     (src_byte),
        .i_last        (src_last),
        .o_valid       (res_valid),
        .i_stall       (dst_stall),
        .o_out_byte    (res_byte),
        .o_byte_is_root(res_is_root),
        .o_root_index  (res_root_index),
        .o_done_res    (res_done),
        .o_status      (res_status),
        .o_root_count  (res_count),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    pssp_frame_checker #(.MAGIC(FRAME_MAGIC)) frame_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (src_valid),
        .i_in_stall      (dut_stall),
        .i_in_byte       (src_byte),
        .i_in_last       (src_last),
        .i_res_valid     (res_valid),
        .i_res_stall     (dst_stall),
        .i_res_byte      (res_byte),
        .i_res_is_root   (res_is_root),
        .i_res_root_index(res_root_index),
        .i_res_done      (res_done),
        .i_res_status    (res_status),
        .i_res_count     (res_count),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_backlog       (backlog)
    );

    // result side: random stalls, plus long hold-offs on request
    initial begin
        forever begin
            if (holds_done != holds_asked) begin
                repeat (HOLD_CYCLES) begin
                    dst_stall <= 1'b1;
                    @(posedge clk);
                end
                holds_done++;
            end else begin
                dst_stall <= rx_idle_on && ($urandom_range(99) < 31);
                @(posedge clk);
            end
        end
    end

    // called at a rising edge; returns at the edge that took the item
    task automatic send_byte(input logic [7:0] b, input bit fin);
        bit took;
        while (tx_idle_on && $urandom_range(99) < 31) begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_byte <= b;
        src_last <= fin;
        do begin
            @(negedge clk);
            took = !dut_stall;
            @(posedge clk);
        end while (!took);
        items_sent++;
    endtask

    task automatic send_frame();
        logic [7:0] b;
        while (frame_q.size() != 0) begin
            b = frame_q.pop_front();
            send_byte(b, frame_q.size() == 0);
        end
    endtask

    task automatic drain();
        src_valid <= 1'b0;
        do @(negedge clk); while (backlog != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end while (!took);
        cfg_valid <= 1'b0;
        if (idx == CFG_EXPECTED_VERSION) cur_ver = val;
        else if (idx == CFG_ROOT_CAPACITY) cur_cap = val;
        @(posedge clk);
    endtask

    // header plus nroots strictly ascending, non-zero roots
    task automatic build_frame(input logic [15:0] ver, input logic [15:0] cnt,
                               input int nroots);
        logic [7:0] r [ROOT_LEN];
        int q;
        frame_q.delete();
        for (int i = 0; i < 8; i++) frame_q.push_back(FRAME_MAGIC[63 - 8*i -: 8]);
        frame_q.push_back(ver[7:0]);
        frame_q.push_back(ver[15:8]);
        frame_q.push_back(cnt[7:0]);
        frame_q.push_back(cnt[15:8]);
        for (int k = 0; k < nroots; k++) begin
            if (k == 0) begin
                if ($urandom_range(3) == 0) begin
                    foreach (r[j]) r[j] = 8'd0;
                    r[$urandom_range(ROOT_LEN - 1)] = 8'($urandom_range(1, 255));
                end else begin
                    foreach (r[j]) r[j] = 8'($urandom);
                end
            end else begin
                // keep a random-length prefix, raise one byte, randomize the tail
                q = $urandom_range(ROOT_LEN - 1);
                while (q >= 0 && r[q] == 8'hFF) q--;
                if (q < 0) begin
                    q = 0;
                    while (q < ROOT_LEN && r[q] == 8'hFF) q++;
                end
                if (q < ROOT_LEN) begin
                    r[q] = 8'($urandom_range(r[q] + 1, 255));
                    for (int j = q + 1; j < ROOT_LEN; j++) r[j] = 8'($urandom);
                end
            end
            foreach (r[j]) frame_q.push_back(r[j]);
        end
    endtask

    // overwrite root k: all zero, a copy of root k-1, or that copy with its first non-zero byte lowered
    task automatic spoil_root(input int k, input t_spoil how);
        int base;
        int j;
        base = HDR_LEN + ROOT_LEN * k;
        for (j = 0; j < ROOT_LEN; j++)
            frame_q[base + j] = (how == SPOIL_ZERO) ? 8'h00 : frame_q[base - ROOT_LEN + j];
        if (how == SPOIL_LOWER) begin
            j = 0;
            while (j < ROOT_LEN && frame_q[base + j] == 8'h00) j++;
            if (j < ROOT_LEN) frame_q[base + j] = frame_q[base + j] - 8'd1;
        end
    endtask

    task automatic random_frame();
        int n;
        int extra;
        logic [15:0] ver;
        logic [15:0] cnt;
        if ($urandom_range(99) < 8) begin
            // line noise
            frame_q.delete();
            repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
        end else begin
            n = (cur_cap >= 3 || cur_cap == 0) ? $urandom_range(1, 3)
                                               : $urandom_range(1, cur_cap);
            if ($urandom_range(9) == 0) n += $urandom_range(1, 3);
            ver = cur_ver;
            cnt = 16'(n);
            if ($urandom_range(9) == 0) ver ^= 16'($urandom_range(1, 16'hFFFF));
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(2))
                    0: cnt = 16'd0;
                    1: cnt = 16'($urandom);
                    default: cnt = cur_cap + 16'd1;
                endcase
            end
            build_frame(ver, cnt, n);
            if ($urandom_range(9) == 0)
                frame_q[$urandom_range(7)] ^= 8'($urandom_range(1, 255));
            if ($urandom_range(9) == 0) spoil_root($urandom_range(n - 1), SPOIL_ZERO);
            if (n > 1 && $urandom_range(9) == 0)
                spoil_root($urandom_range(1, n - 1),
                           $urandom_range(1) ? SPOIL_EQUAL : SPOIL_LOWER);
            if ($urandom_range(9) == 0) begin
                if ($urandom_range(1)) begin
                    repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
                end else begin
                    extra = $urandom_range(1, 40);
                    while (extra > 0 && frame_q.size() > 1) begin
                        void'(frame_q.pop_back());
                        extra--;
                    end
                end
            end
        end
        send_frame();
    endtask

    task automatic random_phase(input int items);
        int start;
        start = items_sent;
        while (items_sent - start < items) random_frame();
    endtask

    initial begin
        #(TIMEOUT);
        $display("[proof_set_stream_parser] ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at reset configuration, no idling on either side
        frame_q.delete();
        frame_q.push_back(FRAME_MAGIC[63 -: 8]);
        send_frame();                                   // lone byte
        build_frame(cur_ver, 16'd1, 0);
        void'(frame_q.pop_back());
        send_frame();                                   // header cut short
        build_frame(cur_ver, 16'd0, 0);
        send_frame();                                   // count zero
        build_frame(cur_ver, 16'd1, 0);
        send_frame();                                   // header only
        build_frame(cur_ver, 16'd1, 0);
        frame_q[7] ^= 8'h80;
        send_frame();                                   // bad magic
        build_frame(~cur_ver, 16'd1, 0);
        send_frame();                                   // wrong version
        build_frame(cur_ver, 16'hFFFF, 0);
        send_frame();                                   // count over limit
        build_frame(cur_ver, 16'd1, 1);
        void'(frame_q.pop_back());
        send_frame();                                   // root area short
        build_frame(cur_ver, 16'd1, 1);
        frame_q.push_back(8'($urandom));
        send_frame();                                   // root area long
        build_frame(cur_ver, 16'd1, 1);
        spoil_root(0, SPOIL_ZERO);
        send_frame();
        build_frame(cur_ver, 16'd2, 2);
        spoil_root(1, SPOIL_EQUAL);
        send_frame();
        build_frame(cur_ver, 16'd2, 2);
        spoil_root(1, SPOIL_LOWER);
        send_frame();
        // zero root on a later root wins over the order error of the same root
        build_frame(cur_ver, 16'd3, 3);
        spoil_root(1, SPOIL_ZERO);
        spoil_root(2, SPOIL_LOWER);
        send_frame();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        random_phase(PHASE_ITEMS);
        drain();

        write_reg(CFG_EXPECTED_VERSION, 16'd0);
        write_reg(CFG_ROOT_CAPACITY, 16'd1);
        // back-pressure: output held off while input streams without gaps
        holds_asked++;
        tx_idle_on = 1'b0;
        build_frame(cur_ver, 16'd1, 1);
        send_frame();
        tx_idle_on = 1'b1;
        drain();

        write_reg(CFG_EXPECTED_VERSION, 16'hFFFF);
        write_reg(CFG_ROOT_CAPACITY, 16'hFFFF);
        write_reg(CFG_SPARE_INDEX, 16'($urandom));
        build_frame(cur_ver, 16'(MAX_ROOTS + 1), 0);
        send_frame();
        drain();

        write_reg(CFG_EXPECTED_VERSION, 16'($urandom));
        write_reg(CFG_ROOT_CAPACITY, 16'($urandom_range(2, 8)));
        random_phase(PHASE_ITEMS);
        drain();

        write_reg(CFG_ROOT_CAPACITY, 16'd0);
        random_phase(PHASE_ITEMS / 2);
        drain();

        if (mismatches == 0) begin
            $display("[proof_set_stream_parser] OK");
        end else begin
            $display("[proof_set_stream_parser] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pssp_pkg.sv
hw/rtl/pssp_front.sv
hw/rtl/pssp_queue.sv
hw/rtl/pssp_back.sv
hw/rtl/proof_set_stream_parser.sv
hw/rtl/pssp_chk.sv
verif/pssp_frame_checker.sv
verif/tb_proof_set_stream_parser.sv
